[rtl/interval_heap_min_max_queue_macros.svh]
// ----------------------------------------------------------------------------
// Interval heap queue assertion macros
// Shorthand for clocked properties under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_HEAP_MIN_MAX_QUEUE_MACROS_SVH
`define INTERVAL_HEAP_MIN_MAX_QUEUE_MACROS_SVH

// same-cycle implication
`define IHMMQ_ASSERT_HOLDS(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval heap check failed");

// next-cycle implication
`define IHMMQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval heap check failed");

`endif

[rtl/ihmmq_pkg.sv]
// ----------------------------------------------------------------------------
// Interval heap queue package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package ihmmq_pkg;

	localparam int NODE_DEPTH_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int LIMIT_BITS     = 9;
	localparam int COUNT_BITS     = 10;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_DEL_MIN = 2'd1,
		REQ_DEL_MAX = 2'd2,
		REQ_PEEK    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_IN_CMP,
		S_DL_RT,
		S_DL_SET,
		S_SK_L,
		S_SK_R,
		S_SK_C,
		S_LF_R,
		S_LF_C,
		S_FIN_RD,
		S_FIN
	} fsm_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic signed [31:0]    min_value;
		logic signed [31:0]    max_value;
		logic [COUNT_BITS-1:0] element_count;
		logic                  is_empty;
	} rsp_t;

endpackage

[rtl/ihmmq_ram.sv]
// ----------------------------------------------------------------------------
// Interval heap queue RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ihmmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/interval_heap_min_max_queue.sv]
// ----------------------------------------------------------------------------
// Interval heap min/max queue
// Double-ended priority queue of signed values held as an interval heap.
//
// req channel (valid/ready): one request per transfer, an insert, a removal
// of the minimum or maximum, or a peek. rsp channel (valid/ready): one
// result per request with status, minimum, maximum and element count after
// the request. cfg channel (valid/ready): node limit, always ready.
// Requests are served one at a time. A peek or a refused request passes
// through S_FIN_RD and S_FIN before the next request can be taken. An
// insert or a removal walks the tree levels (at most log2 of the node
// depth), and each level costs a read of the node memories, whose read
// is registered. A new request is taken as soon as the result sits in
// the output register, even if the receiver stalls it.
// Reset empties the queue and sets the node limit to 256; the
// memories are not cleared.
// ----------------------------------------------------------------------------
module interval_heap_min_max_queue #(
	parameter int NODE_DEPTH = ihmmq_pkg::NODE_DEPTH_DEF,
	parameter int VALUE_BITS = ihmmq_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  ihmmq_pkg::req_t                      req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output ihmmq_pkg::rsp_t                      rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ihmmq_pkg::LIMIT_BITS-1:0]     cfg_data
);

	import ihmmq_pkg::*;

	localparam int IW = $clog2(NODE_DEPTH);
	localparam int CW = $clog2(NODE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

	fsm_t state_q, state_d;

	logic [CW-1:0]         count_q, count_d;
	logic                  complete_q, complete_d;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  rsp_valid_q, rsp_valid_d;
	logic                  mode_min_q, mode_min_d;
	logic                  lone_q, lone_d;
	logic                  lift_hi_q, lift_hi_d;
	logic                  chain_q, chain_d;
	logic                  copy_q, copy_d;
	logic                  moved_q, moved_d;
	status_t               stat_q, stat_d;

	logic [IW-1:0]                last_q, last_d;
	logic [IW-1:0]                cur_q, cur_d;
	logic [IW-1:0]                li_q, li_d;
	logic signed [VALUE_BITS-1:0] lv_q, lv_d;
	logic signed [VALUE_BITS-1:0] mv_q, mv_d;
	logic signed [VALUE_BITS-1:0] t_lo_q, t_lo_d;
	logic signed [VALUE_BITS-1:0] cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
	logic signed [VALUE_BITS-1:0] l_lo_q, l_lo_d, l_hi_q, l_hi_d;
	rsp_t                         rsp_q;

	logic [IW-1:0]                rd_addr, lo_wa, hi_wa;
	logic                         lo_we, hi_we;
	logic signed [VALUE_BITS-1:0] lo_wd, hi_wd, rd_lo, rd_hi;

	logic [LW-1:0]                lim;
	logic [SW-1:0]                l_idx, r_idx;
	logic                         l_ok, r_ok, better_l, better_r;
	logic signed [VALUE_BITS-1:0] b1_lo, b1_hi, sel_lo, sel_hi;
	logic [IW-1:0]                b1_idx, sel_idx, parent;
	logic signed [VALUE_BITS-1:0] nc_lo, nc_hi, ch_lo, ch_hi;
	logic signed [VALUE_BITS-1:0] nco_lo, nco_hi, cho_lo, cho_hi;
	logic signed [VALUE_BITS-1:0] lo0, hi0, pv, lf_wd;
	logic                         lf_move, lf_end, rsp_load;
	rsp_t                         rsp_new;

	ihmmq_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_DEPTH)) u_low_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (lo_wa),
		.wdata (lo_wd),
		.raddr (rd_addr),
		.rdata (rd_lo)
	);

	ihmmq_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_DEPTH)) u_high_ram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (hi_wa),
		.wdata (hi_wd),
		.raddr (rd_addr),
		.rdata (rd_hi)
	);

	assign lim = (LW'(limit_q) > LW'(NODE_DEPTH)) ? LW'(NODE_DEPTH) : LW'(limit_q);

	// sink step: pick the better child, swap the key, order both nodes
	assign l_idx    = (SW'(cur_q) << 1) + SW'(1);
	assign r_idx    = (SW'(cur_q) << 1) + SW'(2);
	assign l_ok     = l_idx < SW'(count_q);
	assign r_ok     = r_idx < SW'(count_q);
	assign better_l = l_ok && (mode_min_q ? (l_lo_q < cur_lo_q) : (cur_hi_q < l_hi_q));
	assign b1_lo    = better_l ? l_lo_q : cur_lo_q;
	assign b1_hi    = better_l ? l_hi_q : cur_hi_q;
	assign b1_idx   = better_l ? l_idx[IW-1:0] : cur_q;
	assign better_r = r_ok && (mode_min_q ? (rd_lo < b1_lo) : (b1_hi < rd_hi));
	assign sel_lo   = better_r ? rd_lo : b1_lo;
	assign sel_hi   = better_r ? rd_hi : b1_hi;
	assign sel_idx  = better_r ? r_idx[IW-1:0] : b1_idx;
	assign nc_lo    = mode_min_q ? sel_lo : cur_lo_q;
	assign nc_hi    = mode_min_q ? cur_hi_q : sel_hi;
	assign ch_lo    = mode_min_q ? cur_lo_q : sel_lo;
	assign ch_hi    = mode_min_q ? sel_hi : cur_hi_q;
	assign nco_lo   = (nc_hi < nc_lo) ? nc_hi : nc_lo;
	assign nco_hi   = (nc_hi < nc_lo) ? nc_lo : nc_hi;
	assign cho_lo   = (ch_hi < ch_lo) ? ch_hi : ch_lo;
	assign cho_hi   = (ch_hi < ch_lo) ? ch_lo : ch_hi;

	// lift step: move the parent down while the value beats it
	assign parent  = IW'((li_q - IW'(1)) >> 1);
	assign pv      = lift_hi_q ? rd_hi : rd_lo;
	assign lf_move = (state_q == S_LF_C) && (lift_hi_q ? (pv < lv_q) : (lv_q < pv));
	assign lf_wd   = lf_move ? pv : lv_q;
	assign lf_end  = ((state_q == S_LF_R) && (li_q == '0)) || ((state_q == S_LF_C) && !lf_move);

	// root delete setup
	always_comb begin
		lo0 = mode_min_q ? mv_q : rd_lo;
		hi0 = mode_min_q ? rd_hi : mv_q;
		if (lone_q && last_q == '0) begin
			hi0 = lo0;
		end
	end

	always_comb begin
		rsp_new.status        = stat_q;
		rsp_new.min_value     = '0;
		rsp_new.max_value     = '0;
		rsp_new.element_count = '0;
		rsp_new.is_empty      = (count_q == '0);
		if (count_q != '0) begin
			rsp_new.min_value = 32'(rd_lo);
			rsp_new.max_value = (count_q == CW'(1) && !complete_q) ? 32'(rd_lo) : 32'(rd_hi);
			rsp_new.element_count =
				COUNT_BITS'((SW'(count_q) << 1) - SW'(!complete_q));
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		complete_d  = complete_q;
		mode_min_d  = mode_min_q;
		lone_d      = lone_q;
		lift_hi_d   = lift_hi_q;
		chain_d     = chain_q;
		copy_d      = copy_q;
		moved_d     = moved_q;
		stat_d      = stat_q;
		last_d      = last_q;
		cur_d       = cur_q;
		li_d        = li_q;
		lv_d        = lv_q;
		mv_d        = mv_q;
		t_lo_d      = t_lo_q;
		cur_lo_d    = cur_lo_q;
		cur_hi_d    = cur_hi_q;
		l_lo_d      = l_lo_q;
		l_hi_d      = l_hi_q;
		rd_addr     = IW'(count_q - CW'(1));
		lo_we       = 1'b0;
		hi_we       = 1'b0;
		lo_wa       = li_q;
		hi_wa       = li_q;
		lo_wd       = lf_wd;
		hi_wd       = lf_wd;
		rsp_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					stat_d = ST_DONE;
					lv_d   = VALUE_BITS'(req.value);
					case (req.req_type)
						REQ_INSERT: begin
							if (complete_q) begin
								if (LW'(count_q) >= lim) begin
									stat_d  = ST_FULL;
									state_d = S_FIN_RD;
								end else begin
									count_d    = count_q + CW'(1);
									complete_d = 1'b0;
									last_d     = IW'(count_q);
									li_d       = IW'(count_q);
									lift_hi_d  = 1'b0;
									chain_d    = 1'b1;
									copy_d     = 1'b0;
									moved_d    = 1'b0;
									state_d    = S_LF_R;
								end
							end else begin
								complete_d = 1'b1;
								last_d     = IW'(count_q - CW'(1));
								state_d    = S_IN_CMP;
							end
						end
						REQ_DEL_MIN, REQ_DEL_MAX: begin
							if (count_q == '0) begin
								stat_d  = ST_EMPTY;
								state_d = S_FIN_RD;
							end else begin
								mode_min_d = (req.req_type == REQ_DEL_MIN);
								last_d     = IW'(count_q - CW'(1));
								state_d    = S_DL_RT;
							end
						end
						default: begin
							state_d = S_FIN_RD;
						end
					endcase
				end
			end
			S_IN_CMP: begin
				chain_d = 1'b0;
				copy_d  = 1'b0;
				moved_d = 1'b0;
				li_d    = last_q;
				if (lv_q < rd_lo) begin
					hi_we     = 1'b1;
					hi_wa     = last_q;
					hi_wd     = rd_lo;
					lift_hi_d = 1'b0;
				end else begin
					lift_hi_d = 1'b1;
				end
				state_d = S_LF_R;
			end
			S_DL_RT: begin
				rd_addr = '0;
				t_lo_d  = rd_lo;
				mv_d    = complete_q ? rd_hi : rd_lo;
				lone_d  = complete_q;
				if (complete_q) begin
					complete_d = 1'b0;
				end else begin
					complete_d = 1'b1;
					count_d    = count_q - CW'(1);
				end
				state_d = S_DL_SET;
			end
			S_DL_SET: begin
				if (lone_q && last_q != '0) begin
					hi_we = 1'b1;
					hi_wa = last_q;
					hi_wd = t_lo_q;
				end
				cur_d    = '0;
				cur_lo_d = lo0;
				cur_hi_d = hi0;
				state_d  = S_SK_L;
			end
			S_SK_L: begin
				rd_addr = l_idx[IW-1:0];
				state_d = S_SK_R;
			end
			S_SK_R: begin
				rd_addr = r_idx[IW-1:0];
				l_lo_d  = rd_lo;
				l_hi_d  = rd_hi;
				state_d = S_SK_C;
			end
			S_SK_C: begin
				lo_we = 1'b1;
				hi_we = 1'b1;
				lo_wa = cur_q;
				hi_wa = cur_q;
				lo_wd = nco_lo;
				hi_wd = nco_hi;
				if (sel_idx == cur_q) begin
					state_d = S_FIN_RD;
				end else begin
					cur_d    = sel_idx;
					cur_lo_d = cho_lo;
					cur_hi_d = cho_hi;
					state_d  = S_SK_L;
				end
			end
			S_LF_R, S_LF_C: begin
				if (state_q == S_LF_R && li_q != '0) begin
					rd_addr = parent;
					state_d = S_LF_C;
				end else begin
					lo_we = !lift_hi_q || (copy_q && li_q == last_q);
					hi_we = lift_hi_q;
					if (lf_move) begin
						moved_d = 1'b1;
						li_d    = parent;
						state_d = S_LF_R;
					end
				end
				if (lf_end) begin
					if (chain_q && !moved_q) begin
						chain_d   = 1'b0;
						lift_hi_d = 1'b1;
						li_d      = last_q;
						copy_d    = 1'b1;
						moved_d   = 1'b0;
						state_d   = S_LF_R;
					end else begin
						state_d = S_FIN_RD;
					end
				end
			end
			S_FIN_RD: begin
				rd_addr = '0;
				state_d = S_FIN;
			end
			S_FIN: begin
				rd_addr = '0;
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rsp_valid_d = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			complete_q  <= 1'b1;
			limit_q     <= LIMIT_BITS'(256);
			rsp_valid_q <= 1'b0;
			mode_min_q  <= 1'b0;
			lone_q      <= 1'b0;
			lift_hi_q   <= 1'b0;
			chain_q     <= 1'b0;
			copy_q      <= 1'b0;
			moved_q     <= 1'b0;
			stat_q      <= ST_DONE;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			complete_q  <= complete_d;
			rsp_valid_q <= rsp_valid_d;
			mode_min_q  <= mode_min_d;
			lone_q      <= lone_d;
			lift_hi_q   <= lift_hi_d;
			chain_q     <= chain_d;
			copy_q      <= copy_d;
			moved_q     <= moved_d;
			stat_q      <= stat_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_q   <= last_d;
		cur_q    <= cur_d;
		li_q     <= li_d;
		lv_q     <= lv_d;
		mv_q     <= mv_d;
		t_lo_q   <= t_lo_d;
		cur_lo_q <= cur_lo_d;
		cur_hi_q <= cur_hi_d;
		l_lo_q   <= l_lo_d;
		l_hi_q   <= l_hi_d;
		if (rsp_load) begin
			rsp_q <= rsp_new;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/ihmmq_chk.sv]
// ----------------------------------------------------------------------------
// Interval heap queue checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "interval_heap_min_max_queue_macros.svh"

module ihmmq_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input ihmmq_pkg::rsp_t rsp
);

	import ihmmq_pkg::*;

	`IHMMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`IHMMQ_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp))
	`IHMMQ_ASSERT_HOLDS(a_empty_flag, rsp_valid, rsp.is_empty == (rsp.element_count == '0))
	`IHMMQ_ASSERT_HOLDS(a_empty_zero, rsp_valid && rsp.is_empty, rsp.min_value == '0 && rsp.max_value == '0)
	`IHMMQ_ASSERT_HOLDS(a_refuse_empty, rsp_valid && rsp.status == ST_EMPTY, rsp.is_empty)

endmodule

bind interval_heap_min_max_queue ihmmq_chk u_ihmmq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
